// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertions clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ADW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define ADW_ASSERT_NEXT(label, ante, cons, msg) \
	`ADW_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- src/adw_pkg.sv -----
// ----------------------------------------------------------------------------
// adw_pkg
// shared widths, command and status codes, and state type of the dfs walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adw_pkg;

	localparam int NODES_DEF  = 64;
	localparam int CMD_W      = 2;
	localparam int VTX_W      = 6;
	localparam int ST_W       = 3;
	localparam int DEG_W      = 6;
	localparam int SCAN_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam logic [DEG_W-1:0] DEG_RESET = 6'd3;

	localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SNAPSHOT   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_WALK       = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_ABSENT  = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
	localparam logic [ST_W-1:0] ST_SAME    = 3'd3;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;
	localparam logic [ST_W-1:0] ST_NOWALK  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEGREE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WALK_ORDER = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESULT,
		S_EDGE_A,
		S_EDGE_B,
		S_EDGE_W,
		S_WALK_EVAL,
		S_WALK_POP,
		S_WALK_END
	} state_t;

endpackage

// ----- src/adjacency_matrix_dfs_walker.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_walker
// add vertex and snapshot go to RESULT; add edge reads row a then row b (EDGE_A, EDGE_B),
// writes both rows (EDGE_B, EDGE_W) unless a degree is full; a walk pushes in WALK_EVAL
// and takes the parent back from the stack memory in WALK_POP on each return up the stack
// one request at a time; the result register lets the next request in early
// arst_n clears flags, marks and row valid bits and resets config; memories are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adjacency_matrix_dfs_walker #(
	parameter int NODES = adw_pkg::NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [adw_pkg::IN_DATA_W-1:0] s_tdata,   // command, vertex_a, vertex_b
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [adw_pkg::OUT_DATA_W-1:0] m_tdata,  // visited_vertex, status
	output logic                          m_tlast,
	input  logic                          cfg_wen,
	input  logic [adw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adw_pkg::DEG_W-1:0]     cfg_wdata
);
	import adw_pkg::*;

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int DW = $clog2(NODES + 1);
	localparam int EW = SCAN_W + AW;

	state_t state_q, state_nx;

	logic [DEG_W-1:0] max_degree_q;
	logic             walk_order_q;
	logic [NODES-1:0] present_q;
	logic [NODES-1:0] marks_q;
	logic [NODES-1:0] row_valid_q;
	logic [DW-1:0]    depth_q;
	logic             pend_valid_q;
	logic [AW-1:0]    pend_q;
	logic [AW-1:0]    a_q;
	logic [AW-1:0]    b_q;
	logic [ST_W-1:0]  status_q;
	logic [NODES-1:0] row_a_q;
	logic [NODES-1:0] row_b_q;
	logic [DEG_W:0]   cnt_a_q;
	logic [AW-1:0]    top_v_q;
	logic [SCAN_W-1:0] top_scan_q;

	logic             m_valid_q;
	logic [VTX_W-1:0] m_vertex_q;
	logic [ST_W-1:0]  m_status_q;
	logic             m_last_q;

	logic [NODES-1:0] adj_mem [NODES];
	logic [NODES-1:0] adj_rd_q;
	logic             adj_rd_ok_q;
	logic [AW-1:0]    adj_raddr;
	logic             adj_we;
	logic [AW-1:0]    adj_waddr;
	logic [NODES-1:0] adj_wdata;

	logic [EW-1:0]    stk_mem [NODES];
	logic [EW-1:0]    stk_rd_q;
	logic [AW-1:0]    stk_raddr;
	logic             stk_we;
	logic [AW-1:0]    stk_waddr;

	logic [CMD_W-1:0] in_cmd;
	logic [VTX_W-1:0] in_a, in_b;
	logic [AW-1:0]    a_idx, b_idx;
	logic             a_ok, b_ok, a_pres, b_pres, start_ok;
	logic             accept, out_free;
	logic [NODES-1:0] row, cand;
	logic             has_cand;
	logic [AW-1:0]    w_idx;
	logic [DEG_W:0]   cnt;
	logic             deg_full;
	logic [DW-1:0]    dm1, dm2;
	logic             emit;
	logic [AW-1:0]    emit_v;

	assign in_cmd   = s_tdata[CMD_W-1:0];
	assign in_a     = s_tdata[CMD_W+VTX_W-1:CMD_W];
	assign in_b     = s_tdata[CMD_W+2*VTX_W-1:CMD_W+VTX_W];
	assign a_ok     = {1'b0, in_a} < (VTX_W+1)'(NODES);
	assign b_ok     = {1'b0, in_b} < (VTX_W+1)'(NODES);
	assign a_idx    = in_a[AW-1:0];
	assign b_idx    = in_b[AW-1:0];
	assign a_pres   = a_ok && present_q[a_idx];
	assign b_pres   = b_ok && present_q[b_idx];
	assign start_ok = a_ok && marks_q[a_idx];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign row  = adj_rd_q & {NODES{adj_rd_ok_q}};
	assign cand = row & marks_q & ({NODES{1'b1}} << top_scan_q);
	assign has_cand = |cand;
	assign dm1 = depth_q - DW'(1);
	assign dm2 = depth_q - DW'(2);

	always_comb begin
		w_idx = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				w_idx = AW'(i);
			end
		end
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < NODES; i++) begin
			cnt = cnt + (DEG_W+1)'(row[i]);
		end
	end

	assign deg_full = (cnt_a_q >= {1'b0, max_degree_q}) || (cnt >= {1'b0, max_degree_q});

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						CMD_ADD_EDGE: begin
							state_nx = (in_a != in_b && a_pres && b_pres) ? S_EDGE_A : S_RESULT;
						end
						CMD_WALK: begin
							state_nx = start_ok ? S_WALK_EVAL : S_RESULT;
						end
						default: begin
							state_nx = S_RESULT;
						end
					endcase
				end
			end
			S_RESULT: begin
				if (out_free) state_nx = S_IDLE;
			end
			S_EDGE_A: begin
				state_nx = S_EDGE_B;
			end
			S_EDGE_B: begin
				state_nx = deg_full ? S_RESULT : S_EDGE_W;
			end
			S_EDGE_W: begin
				state_nx = S_RESULT;
			end
			S_WALK_EVAL: begin
				if (out_free && !has_cand) begin
					state_nx = (depth_q == DW'(1)) ? S_WALK_END : S_WALK_POP;
				end
			end
			S_WALK_POP: begin
				state_nx = S_WALK_EVAL;
			end
			S_WALK_END: begin
				if (out_free) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// memory controls and walk emission
	always_comb begin
		adj_raddr = top_v_q;
		adj_we    = 1'b0;
		adj_waddr = a_q;
		adj_wdata = row_a_q | (NODES'(1) << b_q);
		stk_raddr = dm2[AW-1:0];
		stk_we    = 1'b0;
		stk_waddr = dm1[AW-1:0];
		emit      = 1'b0;
		emit_v    = top_v_q;
		unique case (state_q)
			S_IDLE: begin
				adj_raddr = a_idx;
			end
			S_EDGE_A: begin
				adj_raddr = b_q;
			end
			S_EDGE_B: begin
				adj_we = !deg_full;
			end
			S_EDGE_W: begin
				adj_we    = 1'b1;
				adj_waddr = b_q;
				adj_wdata = row_b_q | (NODES'(1) << a_q);
			end
			S_WALK_EVAL: begin
				if (out_free && has_cand) begin
					adj_raddr = w_idx;
					stk_we    = 1'b1;
					emit      = walk_order_q;
					emit_v    = w_idx;
				end else if (out_free) begin
					emit = !walk_order_q;
				end
			end
			S_WALK_POP: begin
				adj_raddr = stk_rd_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		adj_rd_q <= adj_mem[adj_raddr];
		if (stk_we) begin
			stk_mem[stk_waddr] <= {top_scan_q, top_v_q};
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_degree_q <= DEG_RESET;
			walk_order_q <= 1'b0;
			present_q    <= '0;
			marks_q      <= '0;
			row_valid_q  <= '0;
			adj_rd_ok_q  <= 1'b0;
			depth_q      <= '0;
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q     <= state_nx;
			adj_rd_ok_q <= row_valid_q[adj_raddr];
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_MAX_DEGREE: max_degree_q <= cfg_wdata;
					REG_WALK_ORDER: walk_order_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			if (accept) begin
				unique case (in_cmd)
					CMD_ADD_VERTEX: begin
						if (a_ok) present_q[a_idx] <= 1'b1;
					end
					CMD_SNAPSHOT: begin
						marks_q <= present_q;
					end
					CMD_WALK: begin
						if (start_ok) begin
							marks_q[a_idx] <= 1'b0;
							depth_q        <= DW'(1);
							pend_valid_q   <= walk_order_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == S_WALK_EVAL && out_free) begin
				if (has_cand) begin
					marks_q[w_idx] <= 1'b0;
					depth_q        <= depth_q + DW'(1);
				end else begin
					depth_q <= dm1;
				end
			end
			if (emit) begin
				pend_valid_q <= 1'b1;
			end
			if ((state_q == S_RESULT || state_q == S_WALK_END) && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if ((emit && pend_valid_q) ||
				((state_q == S_RESULT || state_q == S_WALK_END) && out_free)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q      <= a_idx;
			b_q      <= b_idx;
			pend_q   <= a_idx;
			top_v_q  <= a_idx;
			top_scan_q <= '0;
			unique case (in_cmd)
				CMD_ADD_VERTEX: begin
					status_q <= !a_ok ? ST_ABSENT : (present_q[a_idx] ? ST_PRESENT : ST_OK);
				end
				CMD_ADD_EDGE: begin
					status_q <= (in_a == in_b) ? ST_SAME :
						((a_pres && b_pres) ? ST_OK : ST_ABSENT);
				end
				CMD_SNAPSHOT: begin
					status_q <= ST_OK;
				end
				default: begin
					status_q <= ST_NOWALK;
				end
			endcase
		end
		if (state_q == S_EDGE_A) begin
			cnt_a_q <= cnt;
			row_a_q <= row;
		end
		if (state_q == S_EDGE_B) begin
			row_b_q  <= row;
			status_q <= deg_full ? ST_FULL : ST_OK;
		end
		if (state_q == S_WALK_EVAL && out_free && has_cand) begin
			top_v_q    <= w_idx;
			top_scan_q <= '0;
		end
		if (state_q == S_WALK_POP) begin
			top_v_q    <= stk_rd_q[AW-1:0];
			top_scan_q <= stk_rd_q[EW-1:AW];
		end
		if (emit) begin
			pend_q <= emit_v;
			if (pend_valid_q) begin
				m_vertex_q <= VTX_W'(pend_q);
				m_status_q <= ST_OK;
				m_last_q   <= 1'b0;
			end
		end
		if (state_q == S_RESULT && out_free) begin
			m_vertex_q <= '0;
			m_status_q <= status_q;
			m_last_q   <= 1'b1;
		end
		if (state_q == S_WALK_END && out_free) begin
			m_vertex_q <= VTX_W'(pend_q);
			m_status_q <= ST_OK;
			m_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_DATA_W-VTX_W-ST_W)'(0), m_status_q, m_vertex_q};
	assign m_tlast  = m_last_q;

endmodule

// ----- src/adw_checker.sv -----
// ----------------------------------------------------------------------------
// adw_checker
// port-level checks on the dfs walker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [adw_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [adw_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	import adw_pkg::*;

	logic [ST_W-1:0]     st;
	logic [VTX_W-1:0]    vx;
	logic                out_stall;
	logic                req_stall;
	logic [OUT_DATA_W:0] out_word;

	assign st        = m_tdata[VTX_W+ST_W-1:VTX_W];
	assign vx        = m_tdata[VTX_W-1:0];
	assign out_stall = m_tvalid && !m_tready;
	assign req_stall = s_tvalid && !s_tready;
	assign out_word  = {m_tlast, m_tdata};

	`ADW_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "result changed")
	`ADW_ASSERT_NEXT(a_req_hold, req_stall, s_tvalid && $stable(s_tdata), "request changed")
	`ADW_ASSERT(a_status_range, m_tvalid |-> st <= ST_NOWALK, "status code out of range")
	`ADW_ASSERT(a_status_single, m_tvalid && st != ST_OK |-> vx == '0 && m_tlast, "bad status")
	`ADW_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken")

endmodule

bind adjacency_matrix_dfs_walker adw_checker u_adw_checker (.*);

// ----- dv/tb_adjacency_matrix_dfs_walker.sv -----
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_dfs_walker
// stream-level check of the dfs walker: directed graph commands, then random
// graph building, snapshots and walks under several degree and order settings,
// each result compared with a built-in model of the graph state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adjacency_matrix_dfs_walker;
	import adw_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VTX_W-1:0] va;
		logic [VTX_W-1:0] vb;
	} request_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic [ST_W-1:0]  status;
		logic             last;
	} visit_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata = '0;   // command, vertex_a, vertex_b
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;        // visited_vertex, status
	logic                    m_tlast;
	logic                    cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [DEG_W-1:0]        cfg_wdata = '0;

	request_t pending_requests[$];
	visit_t   expected_visits[$];
	request_t held_request;
	int       errors = 0;
	int       cycles = 0;
	bit       calm = 1'b0;

	// graph model
	logic [63:0]      adj_rows[64];
	logic [63:0]      present_set;
	logic [63:0]      walk_marks;
	logic [DEG_W-1:0] degree_limit;
	logic             preorder;

	adjacency_matrix_dfs_walker u_top (.*);

	always #2 clk = ~clk;

	function automatic void emit_visit(int vtx, logic [ST_W-1:0] st);
		visit_t v;
		v.vertex = vtx[VTX_W-1:0];
		v.status = st;
		v.last   = 1'b0;
		expected_visits.push_back(v);
	endfunction

	function automatic void walk_graph(int start);
		int          stk_v[64];
		int          stk_scan[64];
		int          depth;
		int          n;
		int          w;
		logic [63:0] cand;
		n = 0;
		if (walk_marks[start] == 1'b0) begin
			emit_visit(0, ST_NOWALK);
			return;
		end
		walk_marks[start] = 1'b0;
		if (preorder) begin
			emit_visit(start, ST_OK);
			n++;
		end
		depth = 1;
		stk_v[0] = start;
		stk_scan[0] = 0;
		while (depth > 0) begin
			cand = adj_rows[stk_v[depth-1]] & walk_marks;
			if (stk_scan[depth-1] < 64)
				cand &= ~64'd0 << stk_scan[depth-1];
			else
				cand = '0;
			if (cand != 0 && depth < 64 && n < 64) begin
				w = 0;
				while (!cand[w]) w++;
				stk_scan[depth-1] = w + 1;
				walk_marks[w] = 1'b0;
				if (preorder) begin
					emit_visit(w, ST_OK);
					n++;
				end
				stk_v[depth] = w;
				stk_scan[depth] = 0;
				depth++;
			end else begin
				depth--;
				if (!preorder && n < 64) begin
					emit_visit(stk_v[depth], ST_OK);
					n++;
				end
			end
		end
	endfunction

	function automatic void predict_command(request_t r);
		visit_t v;
		case (r.cmd)
			CMD_ADD_VERTEX: begin
				if (present_set[r.va]) begin
					emit_visit(0, ST_PRESENT);
				end else begin
					present_set[r.va] = 1'b1;
					emit_visit(0, ST_OK);
				end
			end
			CMD_ADD_EDGE: begin
				if (r.va == r.vb) begin
					emit_visit(0, ST_SAME);
				end else if (!present_set[r.va] || !present_set[r.vb]) begin
					emit_visit(0, ST_ABSENT);
				end else if ($countones(adj_rows[r.va]) >= degree_limit ||
					$countones(adj_rows[r.vb]) >= degree_limit) begin
					emit_visit(0, ST_FULL);
				end else begin
					adj_rows[r.va][r.vb] = 1'b1;
					adj_rows[r.vb][r.va] = 1'b1;
					emit_visit(0, ST_OK);
				end
			end
			CMD_SNAPSHOT: begin
				walk_marks = present_set;
				emit_visit(0, ST_OK);
			end
			default: walk_graph(r.va);
		endcase
		v = expected_visits.pop_back();
		v.last = 1'b1;
		expected_visits.push_back(v);
	endfunction

	// request driver
	always @(posedge clk) begin : drive_requests
		int gap;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_command(held_request);
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					gap = $urandom_range(1, 9) - 1;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					held_request = pending_requests.pop_front();
					s_tdata  <= {2'b00, held_request.vb, held_request.va, held_request.cmd};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : check_visits
		int     stall;
		visit_t exp_v;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_visits.size() == 0) begin
					$error("unexpected result vertex=%0d status=%0d", m_tdata[5:0],
						m_tdata[8:6]);
					errors++;
				end else begin
					exp_v = expected_visits.pop_front();
					if (m_tdata[5:0] !== exp_v.vertex) begin
						$error("visited_vertex exp %0d got %0d", exp_v.vertex, m_tdata[5:0]);
						errors++;
					end
					if (m_tdata[8:6] !== exp_v.status) begin
						$error("status exp %0d got %0d", exp_v.status, m_tdata[8:6]);
						errors++;
					end
					if (m_tlast !== exp_v.last) begin
						$error("last exp %0d got %0d", exp_v.last, m_tlast);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic queue_request(logic [CMD_W-1:0] c, int a, int b);
		request_t r;
		r.cmd = c;
		r.va  = a[VTX_W-1:0];
		r.vb  = b[VTX_W-1:0];
		pending_requests.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_tvalid || expected_visits.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[DEG_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_MAX_DEGREE)
			degree_limit = value[DEG_W-1:0];
		else
			preorder = value[0];
	endtask

	task automatic random_phase(int count, int pool_size);
		int pool[$];
		int k;
		int pick;
		for (k = 0; k < pool_size; k++)
			pool.push_back($urandom_range(0, 63));
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				queue_request($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
			else if (pick < 30)
				queue_request(CMD_ADD_VERTEX, pool[$urandom_range(0, pool_size - 1)], 0);
			else if (pick < 70)
				queue_request(CMD_ADD_EDGE, pool[$urandom_range(0, pool_size - 1)],
					pool[$urandom_range(0, pool_size - 1)]);
			else if (pick < 80)
				queue_request(CMD_SNAPSHOT, $urandom_range(0, 63), $urandom_range(0, 63));
			else
				queue_request(CMD_WALK, pool[$urandom_range(0, pool_size - 1)],
					$urandom_range(0, 63));
		end
		queue_request(CMD_SNAPSHOT, 0, 0);
		for (k = 0; k < 4; k++)
			queue_request(CMD_WALK, pool[$urandom_range(0, pool_size - 1)], 0);
	endtask

	initial begin
		for (int i = 0; i < 64; i++)
			adj_rows[i] = '0;
		present_set  = '0;
		walk_marks   = '0;
		degree_limit = DEG_RESET;
		preorder     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: duplicates, edge checks, walks before and after snapshot
		queue_request(CMD_WALK, 0, 0);
		queue_request(CMD_ADD_VERTEX, 0, 0);
		queue_request(CMD_ADD_VERTEX, 63, 63);
		queue_request(CMD_ADD_VERTEX, 0, 0);
		for (int i = 1; i <= 4; i++)
			queue_request(CMD_ADD_VERTEX, i, 0);
		queue_request(CMD_ADD_EDGE, 0, 0);
		queue_request(CMD_ADD_EDGE, 0, 5);
		queue_request(CMD_ADD_EDGE, 0, 1);
		queue_request(CMD_ADD_EDGE, 0, 2);
		queue_request(CMD_ADD_EDGE, 0, 3);
		queue_request(CMD_ADD_EDGE, 0, 63);
		queue_request(CMD_ADD_EDGE, 1, 2);
		queue_request(CMD_ADD_EDGE, 2, 1);
		queue_request(CMD_ADD_EDGE, 3, 4);
		queue_request(CMD_WALK, 0, 0);
		queue_request(CMD_SNAPSHOT, 0, 0);
		queue_request(CMD_WALK, 63, 0);
		queue_request(CMD_WALK, 0, 0);
		queue_request(CMD_WALK, 0, 0);
		queue_request(CMD_WALK, 5, 0);
		wait_drained();

		write_reg(REG_MAX_DEGREE, 63);
		write_reg(REG_WALK_ORDER, 1);
		random_phase(20, 24);
		wait_drained();

		write_reg(REG_MAX_DEGREE, 0);
		write_reg(REG_WALK_ORDER, 0);
		random_phase(10, 12);
		wait_drained();

		write_reg(REG_MAX_DEGREE, 1);
		write_reg(REG_WALK_ORDER, 1);
		random_phase(10, 16);
		wait_drained();

		// full vertex set, no idling on either side
		calm = 1'b1;
		write_reg(REG_MAX_DEGREE, 63);
		write_reg(REG_WALK_ORDER, 0);
		for (int i = 0; i < 64; i++)
			queue_request(CMD_ADD_VERTEX, i, 0);
		random_phase(10, 64);
		wait_drained();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
